### rtl/core/radar_report_frame_parser_assert.svh
// assertion macros for the radar report frame parser
// expects clk and rst_n in the scope of the module that includes it
`ifndef RADAR_REPORT_FRAME_PARSER_ASSERT_SVH
`define RADAR_REPORT_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, held off during reset
`define RRFP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define RRFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/rrfp_pkg.sv
// shared types and constants of the radar report frame parser
// no dependencies
package rrfp_pkg;

    // frame marks
    localparam logic [7:0]  MIN_HEAD   = 8'h6E;
    localparam logic [7:0]  MIN_TAIL   = 8'h62;
    localparam logic [31:0] STD_HEADER = 32'hF1F2F3F4;
    localparam logic [31:0] STD_FOOTER = 32'hF5F6F7F8;

    // buffer layout
    localparam int          LEAD_BYTES     = 12;
    localparam int          GATES          = 16;
    localparam logic [3:0]  GATE_LAST      = 4'd15;
    localparam logic [15:0] MIN_SIZE       = 16'd5;
    localparam logic [15:0] DLEN_LOW_POS   = 16'd5;
    localparam logic [15:0] FOOTER_START   = 16'd6;
    localparam logic [15:0] ENERGY_START   = 16'd12;
    localparam logic [15:0] ENERGY_END     = 16'd76;
    localparam logic [15:0] MIN_STD_SIZE   = 16'd80;
    localparam logic [15:0] MIN_DECL_LEN   = 16'd70;
    localparam logic [16:0] FOOTER_GAP     = 17'd6;
    localparam logic [16:0] FRAME_OVERHEAD = 17'd10;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    // result status codes
    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_BAD_LENGTH = 3'd1;
    localparam logic [2:0] STATUS_BAD_HEADER = 3'd2;
    localparam logic [2:0] STATUS_SHORT      = 3'd3;
    localparam logic [2:0] STATUS_BAD_FOOTER = 3'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_buffer;
    } byte_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        minimal_frame;
        logic [7:0]  report_kind;
        logic [7:0]  object_state;
        logic [15:0] distance_cm;
        logic [15:0] reserved_word;
        logic [3:0]  energy_index;
        logic [31:0] energy_value;
        logic        last_result;
    } result_item_t;

endpackage

### rtl/core/radar_report_frame_parser.sv
// radar report frame parser, top level
// depends on rrfp_pkg and radar_report_frame_parser_assert.svh
//
// Usage: bytes of one receive buffer enter on the byte channel, one request
// per byte, with end_of_buffer set on the final byte. Nothing comes out until
// that byte is taken. The result channel then gives one request for a
// minimal frame or a failure, or sixteen requests (one per energy gate, the
// last flagged) for a good standard frame.
// Throughput: one byte per cycle when not held off; results leave one per cycle
// while result_ready is high, from the output register, the energy read register.
// Latency: the first result is valid the cycle after the final byte.
// The byte channel holds off (a) the final byte of a buffer while results
// of the previous buffer are still queued, and (b) the write of an energy
// word into a gate entry whose earlier value has not yet been delivered.
// A stalled result receiver only stretches those holds; nothing is dropped.
// Reset clears the byte count, leading bytes, footer and output valid at
// once; the energy memory is not cleared and needs no clearing pass.
`include "radar_report_frame_parser_assert.svh"

module radar_report_frame_parser
    import rrfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    output logic         byte_ready,
    input  byte_item_t   byte_item,
    output logic         result_valid,
    input  logic         result_ready,
    output result_item_t result_item
);

    // buffer state
    logic [15:0] count_reg;
    logic [7:0]  lead_reg [LEAD_BYTES];
    logic [31:0] footer_reg;
    logic [16:0] foff_reg;
    logic [16:0] lim_reg;
    logic        dlen_ok_reg;
    logic [23:0] asm_reg;

    // energy memory and its read register
    logic [31:0] energy_mem [GATES];
    logic [31:0] mem_q_reg;

    // result register
    logic        result_valid_reg;
    logic        success_reg;
    logic [3:0]  gate_reg;
    logic [2:0]  status_reg;
    logic        minimal_reg;
    logic [7:0]  kind_reg;
    logic [7:0]  target_reg;
    logic [15:0] distance_reg;
    logic [15:0] reserved_reg;

    logic [15:0] p;
    logic [7:0]  b;
    logic [15:0] size_next;
    logic [7:0]  lead_cur [LEAD_BYTES];
    logic [16:0] fdiff;
    logic        foot_hit;
    logic [31:0] footer_cur;
    logic        in_energy;
    logic [6:0]  eoff;
    logic [3:0]  wr_idx;
    logic [1:0]  wr_lane;
    logic        mem_we_want;
    logic        mem_we;
    logic        pending;
    logic        res_take;
    logic        slot_free;
    logic        clobber;
    logic        byte_acc;
    logic        fin_load;
    logic [31:0] header;
    logic        is_min;
    logic [2:0]  std_status;
    logic        eval_success;
    logic        rd_en;
    logic [3:0]  rd_addr;
    logic [15:0] dlen;

    assign p = count_reg;
    assign b = byte_item.rx_byte;
    assign size_next = (p == COUNT_MAX) ? p : p + 16'd1;

    // leading bytes as they stand after this byte
    always_comb
    begin
        for (int i = 0; i < LEAD_BYTES; i++)
        begin
            lead_cur[i] = (p == 16'(i)) ? b : lead_reg[i];
        end
    end

    // footer capture at declared length plus six
    assign fdiff    = {1'b0, p} - foff_reg;
    assign foot_hit = (p >= FOOTER_START) && (fdiff[16:2] == 15'd0);

    always_comb
    begin
        footer_cur = footer_reg;
        if (foot_hit)
        begin
            unique case (fdiff[1:0])
                2'd0: footer_cur = {footer_reg[31:8], b};
                2'd1: footer_cur = {footer_reg[31:16], b, footer_reg[7:0]};
                2'd2: footer_cur = {footer_reg[31:24], b, footer_reg[15:0]};
                2'd3: footer_cur = {b, footer_reg[23:0]};
                default: footer_cur = footer_reg;
            endcase
        end
    end

    // energy word position
    assign in_energy   = (p >= ENERGY_START) && (p < ENERGY_END);
    assign eoff        = p[6:0] - ENERGY_START[6:0];
    assign wr_idx      = eoff[5:2];
    assign wr_lane     = eoff[1:0];
    assign mem_we_want = in_energy && (wr_lane == 2'd3);

    // handshake and interlock
    assign pending   = result_valid_reg && success_reg && (gate_reg != GATE_LAST);
    assign res_take  = result_valid_reg && result_ready;
    assign slot_free = !result_valid_reg || (result_ready && !pending);
    assign clobber   = mem_we_want && result_valid_reg && success_reg && (wr_idx > gate_reg);
    assign byte_ready = !clobber && (!byte_item.end_of_buffer || slot_free);
    assign byte_acc  = byte_valid && byte_ready;
    assign fin_load  = byte_acc && byte_item.end_of_buffer;
    assign mem_we    = byte_acc && mem_we_want;

    // frame evaluation on the final byte
    assign header = {lead_cur[3], lead_cur[2], lead_cur[1], lead_cur[0]};
    assign is_min = (size_next >= MIN_SIZE) && (lead_cur[0] == MIN_HEAD)
                    && (lead_cur[4] == MIN_TAIL);

    always_comb
    begin
        priority if (size_next < MIN_STD_SIZE)
            std_status = STATUS_BAD_LENGTH;
        else if (header != STD_HEADER)
            std_status = STATUS_BAD_HEADER;
        else if (!dlen_ok_reg)
            std_status = STATUS_BAD_LENGTH;
        else if ({1'b0, size_next} < lim_reg)
            std_status = STATUS_SHORT;
        else if (footer_cur != STD_FOOTER)
            std_status = STATUS_BAD_FOOTER;
        else
            std_status = STATUS_OK;
    end

    assign eval_success = !is_min && (std_status == STATUS_OK);

    // energy read: first gate on load, next gate as each result leaves
    assign rd_en   = (fin_load && eval_success) || (res_take && pending);
    assign rd_addr = fin_load ? 4'd0 : gate_reg + 4'd1;

    assign dlen = {b, lead_reg[4]};

    // buffer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= 16'd0;
            footer_reg  <= 32'd0;
            foff_reg    <= FOOTER_GAP;
            lim_reg     <= FRAME_OVERHEAD;
            dlen_ok_reg <= 1'b0;
            for (int i = 0; i < LEAD_BYTES; i++)
            begin
                lead_reg[i] <= 8'd0;
            end
        end
        else if (byte_acc)
        begin
            if (byte_item.end_of_buffer)
            begin
                count_reg  <= 16'd0;
                footer_reg <= 32'd0;
                for (int i = 0; i < LEAD_BYTES; i++)
                begin
                    lead_reg[i] <= 8'd0;
                end
            end
            else
            begin
                count_reg  <= size_next;
                footer_reg <= footer_cur;
                for (int i = 0; i < LEAD_BYTES; i++)
                begin
                    lead_reg[i] <= lead_cur[i];
                end
            end
            // declared length is complete at byte five
            if (p == DLEN_LOW_POS)
            begin
                foff_reg    <= {1'b0, dlen} + FOOTER_GAP;
                lim_reg     <= {1'b0, dlen} + FRAME_OVERHEAD;
                dlen_ok_reg <= dlen >= MIN_DECL_LEN;
            end
        end
    end

    // energy word assembly, low lanes first
    always_ff @(posedge clk)
    begin
        if (byte_acc && in_energy)
        begin
            unique case (wr_lane)
                2'd0: asm_reg[7:0]   <= b;
                2'd1: asm_reg[15:8]  <= b;
                2'd2: asm_reg[23:16] <= b;
                2'd3: asm_reg        <= asm_reg;
                default: asm_reg     <= asm_reg;
            endcase
        end
    end

    // energy memory, read before write on the same entry
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            energy_mem[wr_idx] <= {b, asm_reg};
        end
        if (rd_en)
        begin
            mem_q_reg <= energy_mem[rd_addr];
        end
    end

    // result control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            success_reg      <= 1'b0;
            gate_reg         <= 4'd0;
        end
        else if (fin_load)
        begin
            result_valid_reg <= 1'b1;
            success_reg      <= eval_success;
            gate_reg         <= 4'd0;
        end
        else if (res_take)
        begin
            if (pending)
            begin
                gate_reg <= gate_reg + 4'd1;
            end
            else
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // result fields captured with the final byte
    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            status_reg   <= is_min ? STATUS_OK : std_status;
            minimal_reg  <= is_min;
            kind_reg     <= eval_success ? lead_cur[6] : 8'd0;
            reserved_reg <= eval_success ? {lead_cur[11], lead_cur[10]} : 16'd0;
            priority if (is_min)
            begin
                target_reg   <= lead_cur[1];
                distance_reg <= {lead_cur[3], lead_cur[2]};
            end
            else if (eval_success)
            begin
                target_reg   <= lead_cur[7];
                distance_reg <= {lead_cur[9], lead_cur[8]};
            end
            else
            begin
                target_reg   <= 8'd0;
                distance_reg <= 16'd0;
            end
        end
    end

    // output request
    assign result_valid               = result_valid_reg;
    assign result_item.status         = status_reg;
    assign result_item.minimal_frame  = minimal_reg;
    assign result_item.report_kind    = kind_reg;
    assign result_item.object_state   = target_reg;
    assign result_item.distance_cm    = distance_reg;
    assign result_item.reserved_word  = reserved_reg;
    assign result_item.energy_index   = gate_reg;
    assign result_item.energy_value   = success_reg ? mem_q_reg : 32'd0;
    assign result_item.last_result    = !success_reg || (gate_reg == GATE_LAST);

    // checks
    `RRFP_ASSERT_IMP(a_no_clobber, mem_we && result_valid_reg && success_reg, wr_idx <= gate_reg, "energy entry overwritten before delivery")
    `RRFP_ASSERT_NEXT(a_gate_step, res_take && pending, result_valid_reg && (gate_reg == $past(gate_reg) + 4'd1), "gate did not advance by one")
    `RRFP_ASSERT_NEXT(a_clear_after_final, fin_load, (count_reg == 16'd0) && (footer_reg == 32'd0), "buffer state not cleared after final byte")
    `RRFP_ASSERT_IMP(a_single_gate, result_valid_reg && !success_reg, gate_reg == 4'd0, "single result carries a gate number")

endmodule
